// ===== sv/hti_pkg.sv =====
// ----------------------------------------------------------------------------
// hti_pkg
// Shared types and constants of the height-field triangle interpolator.
// ----------------------------------------------------------------------------
package hti_pkg;

  // Default grid dimension bound (rows and columns of the height memory)
  localparam int MAX_DIM_DEF = 256;

  // Field widths
  localparam int POS_W  = 24;            // signed Q15.8 world position
  localparam int HGT_W  = 16;            // unsigned Q8.8 height
  localparam int IDX_W  = 8;             // load row / column
  localparam int DIMR_W = 9;             // num_rows / num_cols register
  localparam int INV_W  = 24;            // unsigned Q8.16 reciprocal cell size
  localparam int HALF_W = 23;            // unsigned Q15.8 half extent
  localparam int GRID_W = 26;            // shifted position, signed
  localparam int PROD_W = 51;            // multiplier product, signed
  localparam int ACC_W  = 37;            // interpolation accumulator, signed
  localparam int FRAC_W = 16;            // Q0.16 cell fraction

  // Fixed-point 1.0 in Q0.16
  localparam logic [FRAC_W:0] ONE_Q16 = 17'h10000;

  // Item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Configuration register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_NUM_ROWS = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_NUM_COLS = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_INV_CELL = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_HALF_W   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_HALF_D   = 3'd4;
  localparam int CFG_ADDR_W = 5;

  // Configuration reset values
  localparam logic [DIMR_W-1:0] NUM_ROWS_RST = 9'd2;
  localparam logic [DIMR_W-1:0] NUM_COLS_RST = 9'd2;
  localparam logic [INV_W-1:0]  INV_CELL_RST = 24'd65536;

  typedef struct packed {
    logic                    func;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_z;
    logic [IDX_W-1:0]        load_row;
    logic [IDX_W-1:0]        load_col;
    logic [HGT_W-1:0]        load_height;
  } hti_in_t;

  typedef struct packed {
    logic             hit;
    logic [HGT_W-1:0] height;
  } hti_out_t;

  typedef struct packed {
    logic [DIMR_W-1:0] num_rows;
    logic [DIMR_W-1:0] num_cols;
    logic [INV_W-1:0]  inv_cell_size;
    logic [HALF_W-1:0] half_width;
    logic [HALF_W-1:0] half_depth;
  } hti_cfg_t;

  // Cell corners: A (r,c), B (r,c+1), C (r+1,c), D (r+1,c+1)
  typedef enum logic [1:0] {
    CRN_A = 2'd0,
    CRN_B = 2'd1,
    CRN_C = 2'd2,
    CRN_D = 2'd3
  } hti_corner_t;

  // Shared multiplier operations
  typedef enum logic [2:0] {
    MUL_NONE = 3'd0,
    MUL_GX   = 3'd1,
    MUL_GZ   = 3'd2,
    MUL_T1   = 3'd3,
    MUL_T2   = 3'd4
  } hti_mul_t;

  // Controller to datapath commands
  typedef struct packed {
    logic        load;
    logic        mem_wr;
    logic        rd_en;
    hti_corner_t rd_corner;
    logic        cap_en;
    hti_corner_t cap_corner;
    hti_mul_t    mul_op;
    logic        acc_load;
    logic        fin;
    logic        fin_hit;
  } hti_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_grid;
  } hti_sts_t;

endpackage

// ===== sv/heightfield_triangle_interp_top.sv =====
// ----------------------------------------------------------------------------
// heightfield_triangle_interp_top
// Terrain height-field store with planar triangle interpolation of queries.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                        | payload
//  ---------+----------------------------------+---------------------------
//  input    | start, busy (taken: start&!busy) | in_item  (hti_in_t)
//  result   | out_valid, one-cycle strobe      | out_item (hti_out_t)
//  config   | cfg_psel/penable/pwrite, pready  | cfg_paddr, cfg_pwdata/prdata
//
// A write item leaves busy low. A query item holds busy through the grid
// products and cell check, and inside the grid through the corner reads and
// interpolation terms too; its result strobes in the first cycle busy is low.
// The work runs on the single shared multiplier (two grid products, two
// interpolation terms) and the four corner reads through the single-port
// height memory. Reset (rst_n low, synchronous) clears the sequencer and
// config registers; the height memory has no reset and entries read before
// being written are undefined. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module heightfield_triangle_interp_top #(
  parameter int MAX_DIM = hti_pkg::MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  hti_pkg::hti_in_t               in_item,
  output logic                           out_valid,
  output hti_pkg::hti_out_t              out_item,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [hti_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import hti_pkg::*;

  hti_cfg_t cfg;
  hti_cmd_t cmd;
  hti_sts_t sts;

  hti_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  hti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_func   (in_item.func),
    .sts       (sts),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  hti_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk      (clk),
    .cfg      (cfg),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

`ifndef ASSERT_OFF
  // A query keeps the block busy in the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.func == FUNC_QUERY)) |=> busy)
    else $error("query accepted but block not busy");

  // A height write completes in its own cycle
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.func == FUNC_WRITE)) |=> (!busy && !out_valid))
    else $error("write item left block busy or produced a result");

  // Results come only at the end of a query
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a query in flight");

  // No two results in consecutive cycles
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // A miss reports zero height
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.hit) |-> (out_item.height == '0))
    else $error("miss result carries a nonzero height");
`endif

endmodule

// ===== sv/hti_regs.sv =====
// ----------------------------------------------------------------------------
// hti_regs
// APB-style configuration registers of the height-field interpolator.
// ----------------------------------------------------------------------------
module hti_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [hti_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready,
  output hti_pkg::hti_cfg_t              cfg
);
  import hti_pkg::*;

  hti_cfg_t             cfg_r;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg        = cfg_r;

  // Write registers, masking data to each register width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_rows      <= NUM_ROWS_RST;
      cfg_r.num_cols      <= NUM_COLS_RST;
      cfg_r.inv_cell_size <= INV_CELL_RST;
      cfg_r.half_width    <= '0;
      cfg_r.half_depth    <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_NUM_ROWS: cfg_r.num_rows      <= cfg_pwdata[DIMR_W-1:0];
        REG_NUM_COLS: cfg_r.num_cols      <= cfg_pwdata[DIMR_W-1:0];
        REG_INV_CELL: cfg_r.inv_cell_size <= cfg_pwdata[INV_W-1:0];
        REG_HALF_W:   cfg_r.half_width    <= cfg_pwdata[HALF_W-1:0];
        REG_HALF_D:   cfg_r.half_depth    <= cfg_pwdata[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_NUM_ROWS: cfg_prdata = 32'(cfg_r.num_rows);
      REG_NUM_COLS: cfg_prdata = 32'(cfg_r.num_cols);
      REG_INV_CELL: cfg_prdata = 32'(cfg_r.inv_cell_size);
      REG_HALF_W:   cfg_prdata = 32'(cfg_r.half_width);
      REG_HALF_D:   cfg_prdata = 32'(cfg_r.half_depth);
      default:      cfg_prdata = '0;
    endcase
  end

endmodule

// ===== sv/hti_ctrl.sv =====
// ----------------------------------------------------------------------------
// hti_ctrl
// Sequencer: grid mapping, cell check, corner reads and interpolation steps.
// ----------------------------------------------------------------------------
module hti_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_func,
  input  hti_pkg::hti_sts_t sts,
  output logic              busy,
  output hti_pkg::hti_cmd_t cmd,
  output logic              out_valid
);
  import hti_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MULX,
    ST_MULZ,
    ST_CHECK,
    ST_RDB,
    ST_RDC,
    ST_RDD,
    ST_RDW,
    ST_PROD1,
    ST_PROD2,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_func == FUNC_QUERY) begin
            cmd.load  = 1'b1;
            state_nxt = ST_MULX;
          end else begin
            cmd.mem_wr = 1'b1;
          end
        end
      end
      ST_MULX: begin
        cmd.mul_op = MUL_GX;
        state_nxt  = ST_MULZ;
      end
      ST_MULZ: begin
        cmd.mul_op = MUL_GZ;
        state_nxt  = ST_CHECK;
      end
      ST_CHECK: begin
        if (!sts.in_grid) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cmd.rd_en     = 1'b1;
          cmd.rd_corner = CRN_A;
          state_nxt     = ST_RDB;
        end
      end
      ST_RDB: begin
        cmd.rd_en      = 1'b1;
        cmd.rd_corner  = CRN_B;
        cmd.cap_en     = 1'b1;
        cmd.cap_corner = CRN_A;
        state_nxt      = ST_RDC;
      end
      ST_RDC: begin
        cmd.rd_en      = 1'b1;
        cmd.rd_corner  = CRN_C;
        cmd.cap_en     = 1'b1;
        cmd.cap_corner = CRN_B;
        state_nxt      = ST_RDD;
      end
      ST_RDD: begin
        cmd.rd_en      = 1'b1;
        cmd.rd_corner  = CRN_D;
        cmd.cap_en     = 1'b1;
        cmd.cap_corner = CRN_C;
        state_nxt      = ST_RDW;
      end
      ST_RDW: begin
        cmd.cap_en     = 1'b1;
        cmd.cap_corner = CRN_D;
        state_nxt      = ST_PROD1;
      end
      ST_PROD1: begin
        cmd.mul_op = MUL_T1;
        state_nxt  = ST_PROD2;
      end
      ST_PROD2: begin
        cmd.mul_op   = MUL_T2;
        cmd.acc_load = 1'b1;
        state_nxt    = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin     = 1'b1;
        cmd.fin_hit = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state and the result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.fin;
    end
  end

endmodule

// ===== sv/hti_datapath.sv =====
// ----------------------------------------------------------------------------
// hti_datapath
// Height memory, shared multiplier, corner registers and result formatting.
// ----------------------------------------------------------------------------
module hti_datapath #(
  parameter int MAX_DIM = hti_pkg::MAX_DIM_DEF
) (
  input  logic              clk,
  input  hti_pkg::hti_cfg_t cfg,
  input  hti_pkg::hti_in_t  in_item,
  input  hti_pkg::hti_cmd_t cmd,
  output hti_pkg::hti_sts_t sts,
  output hti_pkg::hti_out_t out_item
);
  import hti_pkg::*;

  localparam int DIM_W  = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
  localparam int ADDR_W = 2 * DIM_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int LIM_W  = GRID_W + 1;
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

  // Height memory, single port
  logic [HGT_W-1:0]  mem [DEPTH];
  logic [HGT_W-1:0]  mem_q_r;
  logic [ADDR_W-1:0] mem_addr, wr_addr, rd_addr;
  logic              wr_ok;

  // Operand and result registers
  logic [GRID_W-1:0] sx_r, sz_r;
  logic [PROD_W-1:0] gx_r, gz_r;
  logic [HGT_W-1:0]  a_r, b_r, c_r, d_r;
  logic [ACC_W-1:0]  p1_r, p2_r, acc_r;
  logic              out_hit_r;
  logic [HGT_W-1:0]  out_height_r;

  // Grid mapping
  logic [GRID_W-1:0] col_w, row_w;
  logic [LIM_W-1:0]  col_p1, row_p1, cols_eff, rows_eff, max_lim;
  logic [DIM_W-1:0]  row_i, col_i, row_sel, col_sel;
  logic [FRAC_W-1:0] dx, dz;
  logic [FRAC_W:0]   frac_sum, f1, f2;
  logic              tri_lo;

  // Interpolation terms
  logic [FRAC_W:0]          diff1, diff2;
  logic [HGT_W-1:0]         base;
  logic signed [GRID_W-1:0] opa;
  logic signed [INV_W:0]    opb;
  logic signed [PROD_W-1:0] prod;
  logic [ACC_W-1:0]         sum;
  logic [HGT_W-1:0]         h_val;

  // Write address and range check
  assign wr_ok   = ({24'd0, in_item.load_row} < 32'(MAX_DIM)) &&
                   ({24'd0, in_item.load_col} < 32'(MAX_DIM));
  assign wr_addr = {DIM_W'(in_item.load_row), DIM_W'(in_item.load_col)};

  // Integer cell coordinates and limits
  assign col_w    = gx_r[PROD_W-2:24];
  assign row_w    = gz_r[PROD_W-2:24];
  assign col_p1   = {1'b0, col_w} + LIM_W'(1);
  assign row_p1   = {1'b0, row_w} + LIM_W'(1);
  assign max_lim  = LIM_W'(MAX_DIM);
  assign cols_eff = (LIM_W'(cfg.num_cols) > max_lim) ? max_lim : LIM_W'(cfg.num_cols);
  assign rows_eff = (LIM_W'(cfg.num_rows) > max_lim) ? max_lim : LIM_W'(cfg.num_rows);
  assign sts.in_grid = !gx_r[PROD_W-1] && !gz_r[PROD_W-1] &&
                       (col_p1 < cols_eff) && (row_p1 < rows_eff);

  // Fractions and triangle pick along the B-C diagonal
  assign dx       = gx_r[23:8];
  assign dz       = gz_r[23:8];
  assign frac_sum = {1'b0, dx} + {1'b0, dz};
  assign tri_lo   = !frac_sum[FRAC_W];
  assign f1       = tri_lo ? {1'b0, dx} : (ONE_Q16 - {1'b0, dx});
  assign f2       = tri_lo ? {1'b0, dz} : (ONE_Q16 - {1'b0, dz});
  assign diff1    = tri_lo ? ({1'b0, b_r} - {1'b0, a_r}) : ({1'b0, c_r} - {1'b0, d_r});
  assign diff2    = tri_lo ? ({1'b0, c_r} - {1'b0, a_r}) : ({1'b0, b_r} - {1'b0, d_r});
  assign base     = tri_lo ? a_r : d_r;

  // Corner address
  assign row_i = row_w[DIM_W-1:0];
  assign col_i = col_w[DIM_W-1:0];
  always_comb begin
    case (cmd.rd_corner)
      CRN_A:   begin row_sel = row_i;              col_sel = col_i;              end
      CRN_B:   begin row_sel = row_i;              col_sel = col_i + DIM_W'(1);  end
      CRN_C:   begin row_sel = row_i + DIM_W'(1);  col_sel = col_i;              end
      CRN_D:   begin row_sel = row_i + DIM_W'(1);  col_sel = col_i + DIM_W'(1);  end
      default: begin row_sel = row_i;              col_sel = col_i;              end
    endcase
  end
  assign rd_addr  = {row_sel, col_sel};
  assign mem_addr = cmd.mem_wr ? wr_addr : rd_addr;

  // Memory port
  always_ff @(posedge clk) begin
    if (cmd.mem_wr && wr_ok) begin
      mem[mem_addr] <= in_item.load_height;
    end
    if (cmd.rd_en) begin
      mem_q_r <= mem[mem_addr];
    end
  end

  // Multiplier operand select
  always_comb begin
    case (cmd.mul_op)
      MUL_GX:  begin opa = sx_r; opb = {1'b0, cfg.inv_cell_size}; end
      MUL_GZ:  begin opa = sz_r; opb = {1'b0, cfg.inv_cell_size}; end
      MUL_T1:  begin
        opa = {{(GRID_W-FRAC_W-1){diff1[FRAC_W]}}, diff1};
        opb = {{(INV_W-FRAC_W){1'b0}}, f1};
      end
      MUL_T2:  begin
        opa = {{(GRID_W-FRAC_W-1){diff2[FRAC_W]}}, diff2};
        opb = {{(INV_W-FRAC_W){1'b0}}, f2};
      end
      default: begin opa = '0; opb = '0; end
    endcase
  end
  assign prod = opa * opb;

  // Shift the position into grid space and register products
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx_r <= {{(GRID_W-POS_W){in_item.pos_x[POS_W-1]}}, in_item.pos_x} +
              {{(GRID_W-HALF_W){1'b0}}, cfg.half_width};
      sz_r <= {{(GRID_W-HALF_W){1'b0}}, cfg.half_depth} -
              {{(GRID_W-POS_W){in_item.pos_z[POS_W-1]}}, in_item.pos_z};
    end
    case (cmd.mul_op)
      MUL_GX:  gx_r <= prod;
      MUL_GZ:  gz_r <= prod;
      MUL_T1:  p1_r <= prod[ACC_W-1:0];
      MUL_T2:  p2_r <= prod[ACC_W-1:0];
      default: ;
    endcase
  end

  // Capture corner heights from the memory read register
  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      case (cmd.cap_corner)
        CRN_A:   a_r <= mem_q_r;
        CRN_B:   b_r <= mem_q_r;
        CRN_C:   c_r <= mem_q_r;
        CRN_D:   d_r <= mem_q_r;
        default: ;
      endcase
    end
  end

  // Accumulate base plus first term with the rounding half folded in
  always_ff @(posedge clk) begin
    if (cmd.acc_load) begin
      acc_r <= {{(ACC_W-HGT_W-16){1'b0}}, base, 16'd0} + ROUND_HALF + p1_r;
    end
  end

  // Round, clamp to Q8.8 and drop negatives
  assign sum   = acc_r + p2_r;
  assign h_val = sum[ACC_W-1]       ? '0 :
                 (|sum[ACC_W-2:32]) ? '1 : sum[31:16];

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_hit_r    <= cmd.fin_hit;
      out_height_r <= cmd.fin_hit ? h_val : '0;
    end
  end

  assign out_item.hit    = out_hit_r;
  assign out_item.height = out_height_r;

endmodule

// ===== dv/heightfield_triangle_interp_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightfield_triangle_interp_top_tb
// Self-checking bench for the height-field triangle interpolator. Loads
// terrain heights, sends write and query items through the start/busy port
// and checks every result strobe against an in-bench model of the grid
// mapping and the planar triangle interpolation. Runs several register
// settings (degenerate grids, zero and extreme cell reciprocals, extreme
// half extents) with random sender gaps. Query positions are built so that
// only loaded corners are ever read.
// ----------------------------------------------------------------------------
module heightfield_triangle_interp_top_tb;
  import hti_pkg::*;

  localparam int GRID_DIM = MAX_DIM_DEF;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd6;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  hti_in_t     in_item = '0;
  logic        out_valid;
  hti_out_t    out_item;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Bench model state
  hti_cfg_t         grid_cfg;
  logic [HGT_W-1:0] terrain_mem [GRID_DIM*GRID_DIM];
  bit               loaded [GRID_DIM*GRID_DIM];
  hti_in_t          item_q [$];
  hti_out_t         expected_heights_q [$];
  int               idle_pct = 0;
  int               err_cnt = 0;

  heightfield_triangle_interp_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Map a query position to its grid cell; return 1 when it lies inside
  function automatic bit locate(input hti_in_t it, output longint row, output longint col,
                                output longint dx, output longint dz);
    longint rows, cols, sx, sz, gx, gz;
    rows = (grid_cfg.num_rows > GRID_DIM) ? GRID_DIM : longint'(grid_cfg.num_rows);
    cols = (grid_cfg.num_cols > GRID_DIM) ? GRID_DIM : longint'(grid_cfg.num_cols);
    sx = longint'($signed(it.pos_x)) + longint'(grid_cfg.half_width);
    sz = longint'(grid_cfg.half_depth) - longint'($signed(it.pos_z));
    gx = sx * longint'(grid_cfg.inv_cell_size);
    gz = sz * longint'(grid_cfg.inv_cell_size);
    row = 0;
    col = 0;
    dx = 0;
    dz = 0;
    if (gx < 0 || gz < 0) return 1'b0;
    col = gx >>> 24;
    row = gz >>> 24;
    if (row >= rows - 1 || col >= cols - 1) return 1'b0;
    dx = (gx >>> 8) & 64'hFFFF;
    dz = (gz >>> 8) & 64'hFFFF;
    return 1'b1;
  endfunction

  // Planar height inside the chosen triangle of the cell, rounded to Q8.8
  function automatic hti_out_t terrain_height(input hti_in_t it);
    hti_out_t res;
    longint row, col, dx, dz, a, b, c, d, acc, h;
    res = '0;
    if (!locate(it, row, col, dx, dz)) return res;
    a = terrain_mem[row*GRID_DIM + col];
    b = terrain_mem[row*GRID_DIM + col + 1];
    c = terrain_mem[(row+1)*GRID_DIM + col];
    d = terrain_mem[(row+1)*GRID_DIM + col + 1];
    if (dx + dz < 65536)
      acc = a*65536 + (b - a)*dx + (c - a)*dz;
    else
      acc = d*65536 + (c - d)*(65536 - dx) + (b - d)*(65536 - dz);
    h = 0;
    if (acc > 0) begin
      h = (acc + 32768) >>> 16;
      if (h > 65535) h = 65535;
    end
    res.hit = 1'b1;
    res.height = h[HGT_W-1:0];
    return res;
  endfunction

  // Update the model for one accepted item
  function automatic void apply_item(input hti_in_t it);
    if (it.func == FUNC_WRITE)
      terrain_mem[int'(it.load_row)*GRID_DIM + int'(it.load_col)] = it.load_height;
    else
      expected_heights_q.insert(expected_heights_q.size(), terrain_height(it));
  endfunction

  // Driver: present queued items, hold start until the block takes the item
  always @(posedge clk) begin : drive
    bit taken;
    taken = start && !busy;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (taken) apply_item(in_item);
      if (taken || !start) begin
        if (item_q.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
          in_item <= item_q.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result strobe with the oldest expected height
  always @(posedge clk) begin : check
    hti_out_t want;
    if (rst_n && out_valid) begin
      if (expected_heights_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, actual hit %0d height %0d",
                 $time, out_item.hit, out_item.height);
      end else begin
        want = expected_heights_q.pop_front();
        if (out_item.hit !== want.hit) begin
          err_cnt++;
          $display("%0t: hit mismatch, expected %0d, actual %0d",
                   $time, want.hit, out_item.hit);
        end
        if (out_item.height !== want.height) begin
          err_cnt++;
          $display("%0t: height mismatch, expected %0d, actual %0d",
                   $time, want.height, out_item.height);
        end
      end
    end
  end

  function automatic logic [HGT_W-1:0] rand_height();
    case ($urandom_range(7, 0))
      0: return '0;
      1: return '1;
      default: return HGT_W'($urandom());
    endcase
  endfunction

  function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[POS_W-1:0];
  endfunction

  task automatic push_write(input int row, input int col, input logic [HGT_W-1:0] hgt);
    hti_in_t it;
    it.func = FUNC_WRITE;
    it.pos_x = POS_W'($urandom());
    it.pos_z = POS_W'($urandom());
    it.load_row = row[IDX_W-1:0];
    it.load_col = col[IDX_W-1:0];
    it.load_height = hgt;
    loaded[row*GRID_DIM + col] = 1'b1;
    item_q.insert(item_q.size(), it);
  endtask

  // Queue a query; load any corner of its cell that was never written first
  task automatic push_query(input logic [POS_W-1:0] px, input logic [POS_W-1:0] pz);
    hti_in_t it;
    longint row, col, dx, dz;
    int rr, cc;
    it.func = FUNC_QUERY;
    it.pos_x = px;
    it.pos_z = pz;
    it.load_row = IDX_W'($urandom());
    it.load_col = IDX_W'($urandom());
    it.load_height = HGT_W'($urandom());
    if (locate(it, row, col, dx, dz)) begin
      for (rr = int'(row); rr <= int'(row) + 1; rr++)
        for (cc = int'(col); cc <= int'(col) + 1; cc++)
          if (!loaded[rr*GRID_DIM + cc]) push_write(rr, cc, rand_height());
    end
    item_q.insert(item_q.size(), it);
  endtask

  // Aim a query at a random cell with random fractions
  task automatic push_targeted();
    longint rows, cols, gx, gz, inv;
    rows = (grid_cfg.num_rows > GRID_DIM) ? GRID_DIM : longint'(grid_cfg.num_rows);
    cols = (grid_cfg.num_cols > GRID_DIM) ? GRID_DIM : longint'(grid_cfg.num_cols);
    inv = longint'(grid_cfg.inv_cell_size);
    if (rows < 2 || cols < 2 || inv == 0) begin
      push_query(POS_W'($urandom()), POS_W'($urandom()));
    end else begin
      gx = (longint'($urandom_range(cols - 2, 0)) << 24) + longint'($urandom_range(24'hFFFFFF, 0));
      gz = (longint'($urandom_range(rows - 2, 0)) << 24) + longint'($urandom_range(24'hFFFFFF, 0));
      push_query(clamp_pos(gx / inv - longint'(grid_cfg.half_width)),
                 clamp_pos(longint'(grid_cfg.half_depth) - gz / inv));
    end
  endtask

  task automatic feed_random(input int n);
    int k, pick;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(99, 0);
      if (pick < 25) begin
        if (pick < 12)
          push_write($urandom_range(255, 0), $urandom_range(255, 0), rand_height());
        else
          push_write($urandom_range(15, 0), $urandom_range(15, 0), rand_height());
      end else if (pick < 80) begin
        push_targeted();
      end else begin
        push_query(POS_W'($urandom()), POS_W'($urandom()));
      end
    end
  endtask

  // Wait until every queued item is taken and every expected result is in
  task automatic drain();
    while (item_q.size() != 0 || start || expected_heights_q.size() != 0)
      @(negedge clk);
  endtask

  // Hold the sender once mid-phase until the block has answered everything
  task automatic feed(input int n);
    feed_random(n / 2);
    drain();
    feed_random(n - n / 2);
  endtask

  task automatic apb_xfer(input logic wr, input logic [REG_IDX_W-1:0] idx,
                          input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Write one register; for a mapped index, mirror it in the model and read it back
  task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    logic [31:0] rdata, want;
    apb_xfer(1'b1, idx, value, rdata);
    case (idx)
      REG_NUM_ROWS: grid_cfg.num_rows = value[DIMR_W-1:0];
      REG_NUM_COLS: grid_cfg.num_cols = value[DIMR_W-1:0];
      REG_INV_CELL: grid_cfg.inv_cell_size = value[INV_W-1:0];
      REG_HALF_W:   grid_cfg.half_width = value[HALF_W-1:0];
      REG_HALF_D:   grid_cfg.half_depth = value[HALF_W-1:0];
      default: return;
    endcase
    case (idx)
      REG_NUM_ROWS: want = 32'(grid_cfg.num_rows);
      REG_NUM_COLS: want = 32'(grid_cfg.num_cols);
      REG_INV_CELL: want = 32'(grid_cfg.inv_cell_size);
      REG_HALF_W:   want = 32'(grid_cfg.half_width);
      default:      want = 32'(grid_cfg.half_depth);
    endcase
    apb_xfer(1'b0, idx, '0, rdata);
    if (rdata !== want) begin
      err_cnt++;
      $display("%0t: register %0d readback mismatch, expected %0d, actual %0d",
               $time, idx, want, rdata);
    end
  endtask

  // Go idle, let any write in flight retire, then load a new setting
  task automatic configure(input int rows, input int cols, input int inv,
                           input int hw, input int hd, input int idle);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    set_reg(REG_NUM_ROWS, rows);
    set_reg(REG_NUM_COLS, cols);
    set_reg(REG_INV_CELL, inv);
    set_reg(REG_HALF_W, hw);
    set_reg(REG_HALF_D, hd);
    idle_pct = idle;
  endtask

  initial begin
    grid_cfg.num_rows = NUM_ROWS_RST;
    grid_cfg.num_cols = NUM_COLS_RST;
    grid_cfg.inv_cell_size = INV_CELL_RST;
    grid_cfg.half_width = '0;
    grid_cfg.half_depth = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // 4x4 grid, unit cells, origin at the grid center
    configure(4, 4, 32'h010000, 512, 512, 0);
    push_write(0, 0, 16'h0000);
    push_write(0, 1, 16'hFFFF);
    push_write(1, 0, 16'hFFFF);
    push_write(1, 1, 16'h0000);
    push_write(255, 255, 16'hA5A5);
    push_query(-24'sd512, 24'sd512);             // exact corner A
    push_query(-24'sd384, 24'sd384);             // fractions sum to one: upper triangle
    push_query(-24'sd385, 24'sd384);             // just inside the lower triangle
    push_query(-24'sd257, 24'sd257);             // near corner D
    push_query(-24'sd312, 24'sd502);             // lower triangle, large dx
    push_query(-24'sd513, 24'sd512);             // left of grid
    push_query(-24'sd512, 24'sd513);             // above grid
    push_query(24'sd256, 24'sd0);                // last column edge, outside
    push_query(24'sd255, 24'sd0);                // last inner column
    push_query(24'sd0, -24'sd256);               // last row edge, outside
    push_query(24'sd0, -24'sd255);               // last inner row
    push_query(24'sh7FFFFF, 24'sh800000);        // extreme positions
    push_query(24'sh800000, 24'sh7FFFFF);
    push_query(24'sh7FFFFF, 24'sh7FFFFF);
    drain();
    feed(50);

    // Full 256x256 grid
    configure(256, 256, 32'h010000, 32768, 32768, 69);
    feed(100);
    // Row count above the bound, finest cells
    configure(511, 300, 32'hFFFFFF, 0, 0, 0);
    feed(60);
    // Smallest reciprocal, largest half extents
    configure(2, 2, 1, 32'h7FFFFF, 32'h7FFFFF, 31);
    feed(60);
    // Grid too small for any hit
    configure(0, 1, 32'h010000, 1024, 1024, 69);
    feed(30);
    // Zero reciprocal: every position lands on corner A of cell (0,0)
    configure(3, 5, 0, 123456, 7654321, 31);
    feed(50);
    // Odd sizes, fractional cell reciprocal
    configure(17, 33, 32'h028000, 3000, 1500, 0);
    feed(70);
    // Tall narrow grid; a write to an unmapped address changes nothing
    configure(256, 2, 32'h00C000, 100, 40000, 69);
    set_reg(REG_UNMAPPED, 32'hFFFFFFFF);
    feed(60);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
